/* src/dwr_pkg.sv */
// Shared types and constants for the ring-buffer deque.
// No dependencies; imported by dwr_slot_ram and deque_with_reverse_core.
package dwr_pkg;

    // Width of one stored value
    localparam int unsigned DATA_W = 32;

    // Default number of slots
    localparam int unsigned CAPACITY_DEF = 16;

    // Command codes
    typedef enum logic [1:0] {
        CMD_PUSH_HEAD = 2'd0,
        CMD_PUSH_TAIL = 2'd1,
        CMD_POP_HEAD  = 2'd2,
        CMD_REVERSE   = 2'd3
    } cmd_t;

endpackage

/* src/dwr_slot_ram.sv */
// Single-port slot memory of the deque: one write or one read per cycle,
// read data registered. Depends on dwr_pkg.
module dwr_slot_ram
    import dwr_pkg::*;
#(
    parameter int unsigned DEPTH  = CAPACITY_DEF,
    parameter int unsigned ADDR_W = $clog2(CAPACITY_DEF)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write, or registered read of the addressed slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/deque_with_reverse_core.sv */
// Top level of the bounded deque with constant-time reverse.
// Depends on dwr_pkg and dwr_slot_ram.
//
//  channel  | direction | handshake            | beat fields
//  ---------+-----------+----------------------+------------------------------
//  command  | in        | start & !busy        | cmd, push_value
//  result   | out       | done (one cycle)     | ok, pop_value, item_count
//
// For every command the pointer update and the slot memory
// access happen at the accepting edge, and the result beat is shown in the
// next cycle, when the registered memory read data is ready. A new command
// may be accepted in every cycle, so busy stays low. Reset gives an empty
// queue at once; no clearing pass is run. The receiver cannot stall.
module deque_with_reverse_core
    import dwr_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF,
    parameter int unsigned IDX_W    = $clog2(CAPACITY),
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               cmd,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     done,
    output logic                     ok,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [CNT_W-1:0]         item_count
);

    localparam logic [CNT_W:0]   CAP_SUM  = (CNT_W+1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // Pointer state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rev_reg, rev_next;

    // Result stage
    logic             done_reg, ok_reg, popped_reg;
    logic             ok_next, popped_next;

    // Memory port
    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [DATA_W-1:0] mem_rd_data;

    logic             accept;
    cmd_t             cmd_c;
    logic [CNT_W:0]   high_sum, last_sum;
    logic [IDX_W-1:0] high_idx, last_idx, front_dec, front_inc;
    logic             is_full, is_empty, go_low;

    assign accept = start & ~busy;
    assign busy   = 1'b0;
    assign cmd_c  = cmd_t'(cmd);

    // Ring index arithmetic: high_sum stays below twice the capacity
    always_comb
    begin
        high_sum  = (CNT_W+1)'(front_reg) + (CNT_W+1)'(count_reg);
        last_sum  = high_sum - (CNT_W+1)'(1);
        high_idx  = (high_sum >= CAP_SUM) ? IDX_W'(high_sum - CAP_SUM) : IDX_W'(high_sum);
        last_idx  = (last_sum >= CAP_SUM) ? IDX_W'(last_sum - CAP_SUM) : IDX_W'(last_sum);
        front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
        front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);
        is_full   = (count_reg == CAP_CNT);
        is_empty  = (count_reg == '0);
        go_low    = (cmd_c == CMD_PUSH_HEAD) ^ rev_reg;
    end

    // Command decode: next pointers and memory access
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        ok_next     = 1'b0;
        popped_next = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = rev_reg ? last_idx : front_reg;
        if (accept)
        begin
            unique case (cmd_c)
                CMD_PUSH_HEAD, CMD_PUSH_TAIL:
                begin
                    mem_addr = go_low ? front_dec : high_idx;
                    if (!is_full)
                    begin
                        mem_we     = 1'b1;
                        ok_next    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (go_low)
                        begin
                            front_next = front_dec;
                        end
                    end
                end
                CMD_POP_HEAD:
                begin
                    if (!is_empty)
                    begin
                        ok_next     = 1'b1;
                        popped_next = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                        if (!rev_reg)
                        begin
                            front_next = front_inc;
                        end
                    end
                end
                CMD_REVERSE:
                begin
                    ok_next  = 1'b1;
                    rev_next = ~rev_reg;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            done_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            popped_reg <= 1'b0;
        end
        else
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            done_reg   <= accept;
            ok_reg     <= ok_next;
            popped_reg <= popped_next;
        end
    end

    // Slot store
    dwr_slot_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .addr    (mem_addr),
        .wr_data (push_value),
        .rd_data (mem_rd_data)
    );

    // Result beat; count register already holds the post-command value
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign pop_value  = popped_reg ? mem_rd_data : '0;
    assign item_count = count_reg;

endmodule

/* bench/deque_with_reverse_core_tb.sv */
// Self-checking testbench for deque_with_reverse_core: directed corner cases, then
// random command bursts with random idle gaps, checked against a ring-store predictor.
// Depends on dwr_pkg and the deque_with_reverse_core RTL.
module deque_with_reverse_core_tb;
    import dwr_pkg::*;

    localparam int CNT_BITS   = $clog2(CAPACITY_DEF + 1);
    localparam int RAND_ITEMS = 1200;

    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] pop_value;
        logic [CNT_BITS-1:0]      item_count;
    } deque_result_t;

    // Ring-store model of the deque plus the queue of results still owed
    class deque_scoreboard;
        logic signed [DATA_W-1:0] slots [CAPACITY_DEF];
        int                       front_slot;
        int                       fill;
        bit                       flipped;
        deque_result_t            pending_results [$];
        int                       mismatches;
        int                       n_push, n_push_full, n_pop, n_pop_empty, n_rev;
        int                       peak_fill;

        function new();
            front_slot = 0;
            fill       = 0;
            flipped    = 0;
            mismatches = 0;
            n_push = 0; n_push_full = 0; n_pop = 0; n_pop_empty = 0; n_rev = 0;
            peak_fill = 0;
        endfunction

        // Print one mismatch line and count it
        task report(string msg);
            $display("mismatch: %s (t=%0t)", msg, $time);
            mismatches++;
        endtask

        // One accepted command beat: update the model and queue its result
        function void take_command(cmd_t c, logic signed [DATA_W-1:0] v);
            deque_result_t r;
            bit            to_low;
            r.ok        = 1'b0;
            r.pop_value = '0;
            case (c)
                CMD_PUSH_HEAD, CMD_PUSH_TAIL:
                begin
                    if (fill < CAPACITY_DEF)
                    begin
                        // head push lands low unless reversed; tail push the opposite
                        to_low = (c == CMD_PUSH_HEAD) != flipped;
                        if (to_low)
                        begin
                            front_slot = (front_slot + CAPACITY_DEF - 1) % CAPACITY_DEF;
                            slots[front_slot] = v;
                        end
                        else
                            slots[(front_slot + fill) % CAPACITY_DEF] = v;
                        fill++;
                        r.ok = 1'b1;
                        n_push++;
                    end
                    else
                        n_push_full++;
                end
                CMD_POP_HEAD:
                begin
                    if (fill != 0)
                    begin
                        if (!flipped)
                        begin
                            r.pop_value = slots[front_slot];
                            front_slot  = (front_slot + 1) % CAPACITY_DEF;
                        end
                        else
                            r.pop_value = slots[(front_slot + fill - 1) % CAPACITY_DEF];
                        fill--;
                        r.ok = 1'b1;
                        n_pop++;
                    end
                    else
                        n_pop_empty++;
                end
                default:
                begin
                    flipped = !flipped;
                    r.ok    = 1'b1;
                    n_rev++;
                end
            endcase
            r.item_count = fill[CNT_BITS-1:0];
            if (fill > peak_fill)
                peak_fill = fill;
            pending_results.push_back(r);
        endfunction

        // One result beat: compare with the oldest expectation
        task check_result(logic ok, logic signed [DATA_W-1:0] pv,
                          logic [CNT_BITS-1:0] cnt);
            deque_result_t want;
            if (pending_results.size() == 0)
            begin
                report("result beat with nothing pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok)
                    report($sformatf("ok got %0d expected %0d", ok, want.ok));
                if (pv !== want.pop_value)
                    report($sformatf("pop_value got %0d expected %0d", pv, want.pop_value));
                if (cnt !== want.item_count)
                    report($sformatf("item_count got %0d expected %0d",
                                     cnt, want.item_count));
            end
        endtask

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               cmd = CMD_PUSH_HEAD;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     done;
    logic                     ok;
    logic signed [DATA_W-1:0] pop_value;
    logic [CNT_BITS-1:0]      item_count;

    deque_scoreboard sb = new();
    int              beats_taken = 0;

    deque_with_reverse_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .push_value (push_value),
        .done       (done),
        .ok         (ok),
        .pop_value  (pop_value),
        .item_count (item_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("timeout at t=%0t", $time);
        $display("FAIL");
        $finish;
    end

    // Monitor: check the result beat of the previous command, then note this one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(ok, pop_value, item_count);
            if (start && !busy)
            begin
                sb.take_command(cmd_t'(cmd), push_value);
                beats_taken <= beats_taken + 1;
            end
        end
    end

    // Drive one command beat after an idle gap and wait until it is taken
    task automatic send_cmd(input cmd_t c, input logic signed [DATA_W-1:0] v, input int gap);
        int n;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= c;
        push_value <= v;
        n = beats_taken;
        wait (beats_taken != n);
    endtask

    // Hold off the sender until every owed result has come back
    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int   items;
        int   burst_len;
        int   push_pct;
        bit   no_idle;
        int   r;
        int   guard;
        cmd_t c;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, reverse on empty and single value, extremes, full queue
        send_cmd(CMD_POP_HEAD, 32'h1234_5678, 0);
        send_cmd(CMD_REVERSE, 32'h0, 1);
        send_cmd(CMD_PUSH_HEAD, 32'h7fff_ffff, 0);
        send_cmd(CMD_REVERSE, 32'h0, 0);
        send_cmd(CMD_POP_HEAD, 32'h0, 2);
        send_cmd(CMD_PUSH_TAIL, 32'h8000_0000, 0);
        send_cmd(CMD_PUSH_TAIL, 32'h7fff_ffff, 0);
        send_cmd(CMD_PUSH_HEAD, 32'h0000_0000, 0);
        send_cmd(CMD_PUSH_HEAD, 32'hffff_ffff, 3);
        send_cmd(CMD_PUSH_TAIL, 32'haaaa_aaaa, 0);
        send_cmd(CMD_PUSH_HEAD, 32'h5555_5555, 0);
        for (int i = 0; i < 10; i++)
            send_cmd(i[0] ? CMD_PUSH_HEAD : CMD_PUSH_TAIL, $urandom, i % 3);
        send_cmd(CMD_PUSH_HEAD, 32'hdead_beef, 0);
        send_cmd(CMD_PUSH_TAIL, 32'hcafe_f00d, 0);
        send_cmd(CMD_REVERSE, 32'h0, 0);
        send_cmd(CMD_POP_HEAD, 32'h0, 0);
        quiesce();

        // Random bursts with a push/pop bias so the fill level sweeps empty to full
        items = 0;
        while (items < RAND_ITEMS)
        begin
            burst_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 20;
                1:       push_pct = 46;
                default: push_pct = 72;
            endcase
            no_idle = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 4) == 0)
                quiesce();
            for (int i = 0; i < burst_len; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    c = CMD_REVERSE;
                else if (r < 8 + push_pct)
                    c = $urandom_range(0, 1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD;
                else
                    c = CMD_POP_HEAD;
                send_cmd(c, pick_value(), no_idle ? 0 : $urandom_range(0, 19));
                items++;
            end
        end

        // Drain outstanding results, then a few more cycles for stray beats
        start <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (sb.pending() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d commands: %0d pushes (%0d refused when full), %0d pops",
                 beats_taken, sb.n_push + sb.n_push_full, sb.n_push_full,
                 sb.n_pop + sb.n_pop_empty);
        $display("  (%0d refused when empty), %0d reverses, peak fill %0d, %0d mismatches",
                 sb.n_pop_empty, sb.n_rev, sb.peak_fill, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
